### hw/rtl/pqml_pkg.sv
// ----------------------------------------------------------------------------
// pqml_pkg
// Shared types and constants of the pulse-quantized MIDI looper.
// ----------------------------------------------------------------------------
package pqml_pkg;

    localparam int LOOP_PULSES      = 512;
    localparam int PULSE_W          = 9;
    localparam int LEN_W            = 10;
    localparam int EVENTS_PER_PULSE = 16;
    localparam int EV_W             = 4;
    localparam int FILL_W           = 5;
    localparam int PULSES_PER_BEAT  = 8;
    localparam int BEAT_SHIFT       = 3;
    localparam int STORE_DEPTH      = LOOP_PULSES * EVENTS_PER_PULSE;
    localparam int STORE_AW         = PULSE_W + EV_W;
    localparam int EVENT_W          = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = 2;

    localparam logic [3:0] NIB_SYSTEM      = 4'hF;
    localparam logic [3:0] NIB_CONTROL     = 4'hB;
    localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

    localparam logic [1:0] REG_QUANT_SHIFT = 2'd0;
    localparam logic [1:0] REG_AUTO_STOP   = 2'd1;
    localparam logic [1:0] REG_OUT_CHANNEL = 2'd2;

    typedef struct packed {
        logic       is_midi;
        logic       is_sys;
        logic       clr_rise;
        logic       rec_rise;
        logic       rec_fall;
        logic       ply_rise;
        logic       ply_fall;
        logic       clk;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } cmd_t;

endpackage

### hw/rtl/pqml_ram.sv
// ----------------------------------------------------------------------------
// pqml_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pqml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/pqml_front.sv
// ----------------------------------------------------------------------------
// pqml_front
// Accepts input beats, finds knob edges and turns items into commands.
// ----------------------------------------------------------------------------
module pqml_front
    import pqml_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic       s_record_level,
    input  logic       s_play_level,
    input  logic       s_clear_level,
    input  logic       s_clock_rise,
    input  logic [7:0] s_status_in,
    input  logic [7:0] s_data1_in,
    input  logic [7:0] s_data2_in,
    input  logic       init_done,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_din
);
    logic [2:0] knobs_reg, knobs_next;
    logic       accept;

    assign s_ready = init_done && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        q_din.is_midi  = s_req_type;
        q_din.is_sys   = (s_status_in[7:4] == NIB_SYSTEM);
        q_din.clr_rise = s_clear_level && !knobs_reg[2];
        q_din.rec_rise = s_record_level && !knobs_reg[0];
        q_din.rec_fall = !s_record_level && knobs_reg[0];
        q_din.ply_rise = s_play_level && !knobs_reg[1];
        q_din.ply_fall = !s_play_level && knobs_reg[1];
        q_din.clk      = s_clock_rise;
        q_din.status   = s_status_in;
        q_din.data1    = s_data1_in;
        q_din.data2    = s_data2_in;
        // Messages off channel 1 have no effect at all and are dropped here.
        q_push = accept && (!s_req_type || (s_status_in[3:0] == 4'd0));
        knobs_next = knobs_reg;
        if (accept && !s_req_type) begin
            knobs_next = {s_clear_level, s_play_level, s_record_level};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knobs_reg <= 3'd0;
        end else begin
            knobs_reg <= knobs_next;
        end
    end
endmodule

### hw/rtl/pqml_queue.sv
// ----------------------------------------------------------------------------
// pqml_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module pqml_queue
    import pqml_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic valid
);
    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slots_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wptr_reg] <= din;
        end
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

### hw/rtl/pqml_back.sv
// ----------------------------------------------------------------------------
// pqml_back
// Carries out commands: knob effects, bucket clears, recording, playback
// and the output register.
// ----------------------------------------------------------------------------
module pqml_back
    import pqml_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_wdata,
    input  logic       q_valid,
    input  cmd_t       q_dout,
    output logic       q_pop,
    output logic       init_done,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_status_out,
    output logic [7:0] m_data1_out,
    output logic [7:0] m_data2_out,
    output logic       m_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CLK, S_FRD, S_SADDR, S_SOUT, S_ADV, S_ECHO, S_MQ, S_MFILL
    } state_t;

    state_t               state_reg, state_next;
    logic [PULSE_W-1:0]   sweep_reg, sweep_next;
    logic                 init_reg, init_next;
    logic                 clkp_reg, clkp_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [PULSE_W-1:0]   pp_reg, pp_next;
    logic [LEN_W-1:0]     loop_reg, loop_next;
    logic [PULSE_W-1:0]   lep_reg, lep_next;
    logic                 rec_reg, rec_next;
    logic                 play_reg, play_next;
    logic                 armed_reg, armed_next;
    logic [FILL_W-1:0]    cnt_reg, cnt_next;
    logic [FILL_W-1:0]    idx_reg, idx_next;
    logic [PULSE_W-1:0]   qp_reg, qp_next;
    logic [1:0]           qs_reg, qs_next;
    logic [4:0]           asb_reg, asb_next;
    logic [3:0]           ch_reg, ch_next;
    logic                 ov_reg, ov_next;
    logic [7:0]           ost_reg, ost_next;
    logic [7:0]           od1_reg, od1_next;
    logic [7:0]           od2_reg, od2_next;
    logic                 olast_reg, olast_next;

    logic                 fill_we;
    logic [PULSE_W-1:0]   fill_waddr, fill_raddr;
    logic [FILL_W-1:0]    fill_wdata, fill_rdata;
    logic                 store_we;
    logic [STORE_AW-1:0]  store_waddr, store_raddr;
    logic [EVENT_W-1:0]   store_rdata;

    logic                 slot_free, wrap;
    logic [LEN_W-1:0]     beat_len, pp_inc, thr, q_one, q_sum, qp_wide;
    logic [PULSE_W-1:0]   pp_sat, qp_calc;

    pqml_ram #(.WIDTH(FILL_W), .DEPTH(LOOP_PULSES)) u_fill (
        .aclk(aclk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
        .raddr(fill_raddr), .rdata(fill_rdata)
    );

    pqml_ram #(.WIDTH(EVENT_W), .DEPTH(STORE_DEPTH)) u_store (
        .aclk(aclk), .we(store_we), .waddr(store_waddr),
        .wdata({cmd_reg.status, cmd_reg.data1, cmd_reg.data2}),
        .raddr(store_raddr), .rdata(store_rdata)
    );

    assign init_done    = init_reg;
    assign m_valid      = ov_reg;
    assign m_status_out = ost_reg;
    assign m_data1_out  = od1_reg;
    assign m_data2_out  = od2_reg;
    assign m_last       = olast_reg;
    assign slot_free    = !ov_reg || m_ready;
    assign store_raddr  = {pp_reg, idx_reg[EV_W-1:0]};
    assign store_waddr  = {qp_reg, fill_rdata[EV_W-1:0]};

    always_comb begin
        // Loop length rounded up to the beat after the last recorded pulse.
        beat_len = (({1'b0, lep_reg} + LEN_W'(PULSES_PER_BEAT)) >> BEAT_SHIFT) << BEAT_SHIFT;
        pp_inc   = {1'b0, pp_reg} + 1'b1;
        wrap     = (pp_inc >= loop_reg);
        pp_sat   = (pp_reg == PULSE_W'(LOOP_PULSES - 1)) ? pp_reg : pp_inc[PULSE_W-1:0];
        thr      = LEN_W'(asb_reg) << BEAT_SHIFT;
        q_one    = LEN_W'(1) << qs_reg;
        q_sum    = {1'b0, pp_reg} + (q_one >> 1);
        qp_wide  = q_sum & ~(q_one - 1'b1);
        qp_calc  = (qp_wide >= LEN_W'(LOOP_PULSES)) ? PULSE_W'(LOOP_PULSES - 1)
                                                     : qp_wide[PULSE_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        init_next  = init_reg;
        clkp_next  = clkp_reg;
        cmd_next   = cmd_reg;
        pp_next    = pp_reg;
        loop_next  = loop_reg;
        lep_next   = lep_reg;
        rec_next   = rec_reg;
        play_next  = play_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        qp_next    = qp_reg;
        qs_next    = qs_reg;
        asb_next   = asb_reg;
        ch_next    = ch_reg;
        ov_next    = ov_reg && !m_ready;
        ost_next   = ost_reg;
        od1_next   = od1_reg;
        od2_next   = od2_reg;
        olast_next = olast_reg;
        q_pop      = 1'b0;
        fill_we    = 1'b0;
        fill_waddr = qp_reg;
        fill_wdata = fill_rdata + 1'b1;
        fill_raddr = pp_reg;
        store_we   = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_QUANT_SHIFT: qs_next  = cfg_wdata[1:0];
                REG_AUTO_STOP:   asb_next = cfg_wdata;
                REG_OUT_CHANNEL: ch_next  = cfg_wdata[3:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_dout;
                    if (q_dout.is_midi) begin
                        state_next = S_ECHO;
                    end else begin
                        // Knob edges in order: clear, record, play.
                        if (q_dout.clr_rise) begin
                            loop_next = '0;
                            pp_next   = '0;
                            rec_next  = 1'b0;
                            play_next = 1'b0;
                            lep_next  = '0;
                        end
                        if (q_dout.rec_rise) begin
                            play_next  = 1'b0;
                            rec_next   = 1'b0;
                            armed_next = 1'b1;
                            pp_next    = '0;
                            lep_next   = '0;
                            loop_next  = '0;
                        end else if (q_dout.rec_fall) begin
                            if (rec_next) begin
                                loop_next = beat_len;
                            end
                            rec_next   = 1'b0;
                            armed_next = 1'b0;
                        end
                        if (q_dout.ply_rise) begin
                            if (loop_next != '0 && !rec_next) begin
                                play_next = 1'b1;
                                pp_next   = '0;
                            end
                        end else if (q_dout.ply_fall) begin
                            play_next = 1'b0;
                        end
                        clkp_next = q_dout.clk;
                        if (q_dout.clr_rise || q_dout.rec_rise) begin
                            sweep_next = '0;
                            state_next = S_CLR;
                        end else if (q_dout.clk) begin
                            state_next = S_CLK;
                        end
                    end
                end
            end
            S_CLR: begin
                fill_we    = 1'b1;
                fill_waddr = sweep_reg;
                fill_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == PULSE_W'(LOOP_PULSES - 1)) begin
                    init_next  = 1'b1;
                    state_next = clkp_reg ? S_CLK : S_IDLE;
                end
            end
            S_CLK: begin
                state_next = S_IDLE;
                if (rec_reg) begin
                    pp_next = pp_sat;
                    if (asb_reg != '0 && {1'b0, pp_sat} >= thr) begin
                        loop_next  = beat_len;
                        rec_next   = 1'b0;
                        armed_next = 1'b0;
                        play_next  = 1'b1;
                        pp_next    = '0;
                    end
                end else if (!armed_reg && play_reg && loop_reg != '0) begin
                    state_next = S_FRD;
                end
            end
            S_FRD: begin
                cnt_next = fill_rdata;
                idx_next = '0;
                if ({1'b0, pp_reg} < loop_reg && fill_rdata != '0) begin
                    state_next = S_SADDR;
                end else begin
                    state_next = S_ADV;
                end
            end
            S_SADDR: begin
                state_next = S_SOUT;
            end
            S_SOUT: begin
                if (slot_free) begin
                    ov_next    = 1'b1;
                    ost_next   = {store_rdata[23:20], ch_reg};
                    od1_next   = store_rdata[15:8];
                    od2_next   = store_rdata[7:0];
                    olast_next = (idx_reg + 1'b1 == cnt_reg) && !wrap;
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == cnt_reg) ? S_ADV : S_SADDR;
                end
            end
            S_ADV: begin
                if (!wrap) begin
                    pp_next    = pp_inc[PULSE_W-1:0];
                    state_next = S_IDLE;
                end else if (slot_free) begin
                    ov_next    = 1'b1;
                    ost_next   = {NIB_CONTROL, ch_reg};
                    od1_next   = CC_ALL_NOTES_OFF;
                    od2_next   = 8'd0;
                    olast_next = 1'b1;
                    pp_next    = '0;
                    state_next = S_IDLE;
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    ov_next    = 1'b1;
                    ost_next   = {cmd_reg.status[7:4], ch_reg};
                    od1_next   = cmd_reg.data1;
                    od2_next   = cmd_reg.data2;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                    if (!cmd_reg.is_sys) begin
                        // An armed recorder starts on the first recordable message.
                        if (armed_reg && !rec_reg) begin
                            rec_next   = 1'b1;
                            armed_next = 1'b0;
                            pp_next    = '0;
                        end
                        if (rec_reg || armed_reg) begin
                            state_next = S_MQ;
                        end
                    end
                end
            end
            S_MQ: begin
                fill_raddr = qp_calc;
                qp_next    = qp_calc;
                state_next = S_MFILL;
            end
            S_MFILL: begin
                if (fill_rdata < FILL_W'(EVENTS_PER_PULSE)) begin
                    store_we = 1'b1;
                    fill_we  = 1'b1;
                    lep_next = qp_reg;
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            sweep_reg <= '0;
            init_reg  <= 1'b0;
            clkp_reg  <= 1'b0;
            pp_reg    <= '0;
            loop_reg  <= '0;
            lep_reg   <= '0;
            rec_reg   <= 1'b0;
            play_reg  <= 1'b0;
            armed_reg <= 1'b0;
            qs_reg    <= 2'd0;
            asb_reg   <= 5'd0;
            ch_reg    <= 4'd1;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            init_reg  <= init_next;
            clkp_reg  <= clkp_next;
            pp_reg    <= pp_next;
            loop_reg  <= loop_next;
            lep_reg   <= lep_next;
            rec_reg   <= rec_next;
            play_reg  <= play_next;
            armed_reg <= armed_next;
            qs_reg    <= qs_next;
            asb_reg   <= asb_next;
            ch_reg    <= ch_next;
            ov_reg    <= ov_next;
        end
        cmd_reg   <= cmd_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        qp_reg    <= qp_next;
        ost_reg   <= ost_next;
        od1_reg   <= od1_next;
        od2_reg   <= od2_next;
        olast_reg <= olast_next;
    end
endmodule

### hw/rtl/pulse_quantized_midi_looper_core.sv
// ----------------------------------------------------------------------------
// pulse_quantized_midi_looper_core
// MIDI looper keyed to an external clock, with quantized recording into
// per-pulse buckets and looped playback.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Direction
//  input     s_valid/s_ready, s_* fields            in (step or MIDI beat)
//  result    m_valid/m_ready, m_* fields, m_last    out (MIDI message beat)
//  config    cfg_wr_en, cfg_index, cfg_wdata        in (write only)
//
// A MIDI beat is echoed and, when recording, stored in its bucket. A clock step
// in playback reads the bucket count, then replays its events; each event is one
// store read. A clear or record edge sweeps the 512-entry bucket counts,
// one per cycle, and the same sweep runs after reset with s_ready
// low. A four-entry command queue lets the input side run ahead of the back
// end, and the output register holds a result while the next one is formed.
// ----------------------------------------------------------------------------
module pulse_quantized_midi_looper_core
    import pqml_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic       s_record_level,
    input  logic       s_play_level,
    input  logic       s_clear_level,
    input  logic       s_clock_rise,
    input  logic [7:0] s_status_in,
    input  logic [7:0] s_data1_in,
    input  logic [7:0] s_data2_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_status_out,
    output logic [7:0] m_data1_out,
    output logic [7:0] m_data2_out,
    output logic       m_last
);
    logic init_done, q_full, q_push, q_pop, q_valid;
    cmd_t q_din, q_dout;

    pqml_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_record_level(s_record_level), .s_play_level(s_play_level),
        .s_clear_level(s_clear_level), .s_clock_rise(s_clock_rise),
        .s_status_in(s_status_in), .s_data1_in(s_data1_in), .s_data2_in(s_data2_in),
        .init_done(init_done), .q_full(q_full), .q_push(q_push), .q_din(q_din)
    );

    pqml_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .din(q_din), .full(q_full),
        .pop(q_pop), .dout(q_dout), .valid(q_valid)
    );

    pqml_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_dout(q_dout), .q_pop(q_pop), .init_done(init_done),
        .m_valid(m_valid), .m_ready(m_ready), .m_status_out(m_status_out),
        .m_data1_out(m_data1_out), .m_data2_out(m_data2_out), .m_last(m_last)
    );
endmodule

### dv/pulse_quantized_midi_looper_core_test.sv
// ----------------------------------------------------------------------------
// pulse_quantized_midi_looper_core_test
// Drives step and MIDI beats into the looper with random idle gaps on both
// channels, predicts every outgoing message and checks them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pulse_quantized_midi_looper_core_test;
    import pqml_pkg::*;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
        logic       last;
    } midi_msg_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [4:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic       s_req_type;
    logic       s_record_level;
    logic       s_play_level;
    logic       s_clear_level;
    logic       s_clock_rise;
    logic [7:0] s_status_in;
    logic [7:0] s_data1_in;
    logic [7:0] s_data2_in;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_status_out;
    logic [7:0] m_data1_out;
    logic [7:0] m_data2_out;
    logic       m_last;

    pulse_quantized_midi_looper_core uut (.*);

    // Shadow copy of the looper state.
    logic [23:0]  loop_events [STORE_DEPTH];
    int unsigned  loop_fill [LOOP_PULSES];
    int unsigned  loop_pulse;
    int unsigned  loop_length;
    int unsigned  final_pulse;
    bit           is_recording;
    bit           is_playing;
    bit           is_armed;
    bit [2:0]     knob_levels;
    int unsigned  grid_shift;
    int unsigned  stop_beats;
    logic [3:0]   midi_channel;

    midi_msg_t    pending_msgs [$];
    int           error_count;
    bit           rx_hold;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("pulse_quantized_midi_looper_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned rounded_end();
        return ((final_pulse + PULSES_PER_BEAT) / PULSES_PER_BEAT) * PULSES_PER_BEAT;
    endfunction

    function automatic void clear_fill();
        foreach (loop_fill[i]) loop_fill[i] = 0;
    endfunction

    function automatic void push_msg(input logic [7:0] st, input logic [7:0] d1,
                                     input logic [7:0] d2, input logic lst);
        midi_msg_t m;
        m.status = st;
        m.data1  = d1;
        m.data2  = d2;
        m.last   = lst;
        pending_msgs.push_back(m);
    endfunction

    function automatic void predict_midi(input logic [7:0] st, input logic [7:0] d1,
                                         input logic [7:0] d2);
        int unsigned grid;
        int unsigned slot;
        if (st[3:0] != 4'h0) return;
        push_msg({st[7:4], midi_channel}, d1, d2, 1'b1);
        if (st[7:4] == NIB_SYSTEM) return;
        if (is_armed && !is_recording) begin
            is_recording = 1;
            is_armed = 0;
            loop_pulse = 0;
        end
        if (!is_recording) return;
        grid = 1 << grid_shift;
        slot = ((loop_pulse + grid / 2) / grid) * grid;
        if (slot >= LOOP_PULSES) slot = LOOP_PULSES - 1;
        if (loop_fill[slot] < EVENTS_PER_PULSE) begin
            loop_events[slot * EVENTS_PER_PULSE + loop_fill[slot]] = {st, d1, d2};
            loop_fill[slot]++;
            final_pulse = slot;
        end
    endfunction

    function automatic void predict_step(input bit rec, input bit ply, input bit clr,
                                         input bit clk);
        int n;
        logic [23:0] e;
        n = 0;
        if (clr && !knob_levels[2]) begin
            clear_fill();
            loop_length = 0;
            loop_pulse = 0;
            is_recording = 0;
            is_playing = 0;
            final_pulse = 0;
        end
        if (rec && !knob_levels[0]) begin
            is_playing = 0;
            is_recording = 0;
            is_armed = 1;
            loop_pulse = 0;
            final_pulse = 0;
            clear_fill();
            loop_length = 0;
        end else if (!rec && knob_levels[0]) begin
            if (is_recording) loop_length = rounded_end();
            is_recording = 0;
            is_armed = 0;
        end
        if (ply && !knob_levels[1]) begin
            if (loop_length > 0 && !is_recording) begin
                is_playing = 1;
                loop_pulse = 0;
            end
        end else if (!ply && knob_levels[1]) begin
            is_playing = 0;
        end
        knob_levels = {clr, ply, rec};
        if (!clk) return;
        if (is_recording) begin
            loop_pulse++;
            if (loop_pulse >= LOOP_PULSES) loop_pulse = LOOP_PULSES - 1;
            if (stop_beats > 0 && loop_pulse >= stop_beats * PULSES_PER_BEAT) begin
                loop_length = rounded_end();
                is_recording = 0;
                is_armed = 0;
                is_playing = 1;
                loop_pulse = 0;
            end
        end else if (!is_armed && is_playing && loop_length > 0) begin
            if (loop_pulse < loop_length && loop_pulse < LOOP_PULSES) begin
                for (int i = 0; i < loop_fill[loop_pulse]; i++) begin
                    e = loop_events[loop_pulse * EVENTS_PER_PULSE + i];
                    push_msg({e[23:20], midi_channel}, e[15:8], e[7:0], 1'b0);
                    n++;
                end
            end
            loop_pulse++;
            if (loop_pulse >= loop_length) begin
                push_msg({NIB_CONTROL, midi_channel}, CC_ALL_NOTES_OFF, 8'd0, 1'b0);
                n++;
                loop_pulse = 0;
            end
            if (n > 0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int unsigned gap_length();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sends one beat and updates the prediction when it is accepted. The task
    // returns at the accepting edge; valid drops at the next idle gap.
    task automatic send_beat(input bit is_midi, input bit rec, input bit ply, input bit clr,
                             input bit clk, input logic [7:0] st, input logic [7:0] d1,
                             input logic [7:0] d2);
        int unsigned gap;
        gap = gap_length();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= is_midi;
        s_record_level <= rec;
        s_play_level   <= ply;
        s_clear_level  <= clr;
        s_clock_rise   <= clk;
        s_status_in    <= st;
        s_data1_in     <= d1;
        s_data2_in     <= d2;
        do @(posedge aclk); while (!s_ready);
        if (is_midi) predict_midi(st, d1, d2);
        else predict_step(rec, ply, clr, clk);
    endtask

    task automatic send_step(input bit rec, input bit ply, input bit clr, input bit clk);
        send_beat(1'b0, rec, ply, clr, clk, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_midi(input logic [7:0] st, input logic [7:0] d1, input logic [7:0] d2);
        send_beat(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), st, d1, d2);
    endtask

    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_msgs.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        // Bucket sweeps run without producing messages.
        repeat (1200) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 5'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_QUANT_SHIFT: grid_shift = value & 3;
            REG_AUTO_STOP:   stop_beats = value & 31;
            REG_OUT_CHANNEL: midi_channel = 4'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned q, input int unsigned a, input int unsigned c);
        wait_idle();
        write_reg(REG_QUANT_SHIFT, q);
        write_reg(REG_AUTO_STOP, a);
        write_reg(REG_OUT_CHANNEL, c);
    endtask

    function automatic logic [7:0] random_status();
        logic [7:0] st;
        st = 8'($urandom);
        if ($urandom_range(9) < 8) st[3:0] = 4'h0;
        if ($urandom_range(9) < 7 && st[7:4] == NIB_SYSTEM) st[7:4] = 4'h9;
        if (st[7] == 1'b0 && $urandom_range(3) != 0) st[7] = 1'b1;
        return st;
    endfunction

    // Record a few pulses of notes, close the loop and play it through.
    task automatic run_take(input int unsigned pulses, input int unsigned plays,
                            input bit keep_record_high);
        send_step(1, 0, 0, 0);
        for (int p = 0; p < pulses; p++) begin
            repeat ($urandom_range(2)) send_midi(random_status(), 8'($urandom), 8'($urandom));
            send_step(1, 0, 0, 1);
        end
        send_step(keep_record_high, 0, 0, 0);
        send_step(0, 1, 0, 0);
        repeat (plays) send_step(0, 1, 0, 1);
        send_step(0, 0, 0, $urandom_range(1));
    endtask

    task automatic test_directed();
        set_config(0, 0, 1);
        // Echo extremes and system messages while idle; other channels are dropped.
        send_midi(8'h90, 8'h00, 8'h00);
        send_midi(8'hF0, 8'hFF, 8'hFF);
        send_midi(8'h91, 8'h3C, 8'h40);
        send_midi(8'h00, 8'h7F, 8'h7F);
        send_midi(8'hFF, 8'h12, 8'h34);
        // Play with no loop is ignored.
        send_step(0, 1, 0, 1);
        send_step(0, 0, 0, 1);
        // Armed recorder waits for its first note; system messages do not start it.
        send_step(1, 0, 0, 1);
        send_midi(8'hF0, 8'h01, 8'h02);
        send_step(1, 0, 0, 1);
        send_midi(8'h90, 8'h40, 8'h7F);
        send_step(1, 0, 0, 1);
        send_midi(8'h80, 8'h40, 8'h00);
        send_step(1, 1, 0, 1);
        send_step(0, 1, 0, 0);
        send_step(0, 0, 0, 0);
        send_step(0, 1, 0, 0);
        repeat (10) send_step(0, 1, 0, 1);
        // Clear during playback.
        send_step(0, 1, 1, 1);
        send_step(0, 1, 0, 1);
        send_step(0, 0, 0, 1);
    endtask

    task automatic test_bucket_full();
        set_config(3, 0, 15);
        send_step(1, 0, 0, 0);
        repeat (18) send_midi(8'h90, 8'($urandom), 8'($urandom));
        send_step(1, 0, 0, 1);
        send_step(0, 0, 0, 0);
        send_step(0, 1, 0, 0);
        repeat (10) send_step(0, 1, 0, 1);
        send_step(0, 0, 0, 0);
    endtask

    task automatic test_auto_stop();
        set_config(1, 1, 0);
        run_take(10, 8, 1'b1);
        set_config(2, 2, 7);
        run_take(17, 10, 1'b0);
    endtask

    task automatic test_long_record();
        // Recording past the loop end saturates the pulse counter.
        set_config(2, 0, 3);
        send_step(1, 0, 0, 0);
        send_midi(8'hB0, 8'h07, 8'h64);
        repeat (512) send_step(1, 0, 0, 1);
        send_midi(8'hE0, 8'h00, 8'h40);
        send_step(0, 0, 0, 0);
        send_step(0, 1, 0, 0);
        repeat (6) send_step(0, 1, 0, 1);
        send_step(0, 0, 0, 0);
        set_config(0, 31, 9);
        run_take(3, 3, 1'b0);
    endtask

    task automatic test_random();
        for (int t = 0; t < 1; t++) begin
            set_config($urandom_range(3), $urandom_range(4), $urandom_range(15));
            run_take($urandom_range(24, 2), $urandom_range(30, 4), 1'($urandom));
            repeat (12) begin
                if ($urandom_range(3) == 0)
                    send_midi(8'($urandom), 8'($urandom), 8'($urandom));
                else
                    send_step(1'($urandom), 1'($urandom), $urandom_range(7) == 0,
                              1'($urandom));
            end
        end
    endtask

    // Result checker with random back-pressure.
    always @(posedge aclk) begin
        midi_msg_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_msgs.size() == 0) begin
                report_mismatch($sformatf("unexpected message %02h %02h %02h",
                                          m_status_out, m_data1_out, m_data2_out));
            end else begin
                want = pending_msgs.pop_front();
                if (m_status_out !== want.status)
                    report_mismatch($sformatf("status %02h, want %02h", m_status_out,
                                              want.status));
                if (m_data1_out !== want.data1)
                    report_mismatch($sformatf("data1 %02h, want %02h", m_data1_out,
                                              want.data1));
                if (m_data2_out !== want.data2)
                    report_mismatch($sformatf("data2 %02h, want %02h", m_data2_out,
                                              want.data2));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
        end
    end

    initial begin
        int unsigned hold;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b1;
            end else begin
                hold = gap_length();
                if (hold != 0) begin
                    m_ready <= 1'b0;
                    repeat (hold) @(negedge aclk);
                end
                m_ready <= 1'b1;
                hold = $urandom_range(12);
                repeat (hold) @(negedge aclk);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_record_level = 1'b0;
        s_play_level = 1'b0;
        s_clear_level = 1'b0;
        s_clock_rise = 1'b0;
        s_status_in = '0;
        s_data1_in = '0;
        s_data2_in = '0;
        rx_hold = 1'b0;
        error_count = 0;
        clear_fill();
        loop_pulse = 0;
        loop_length = 0;
        final_pulse = 0;
        is_recording = 0;
        is_playing = 0;
        is_armed = 0;
        knob_levels = '0;
        grid_shift = 0;
        stop_beats = 0;
        midi_channel = 4'd1;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_bucket_full();
        test_auto_stop();
        test_long_record();
        test_random();
        wait_idle();
        if (error_count == 0 && pending_msgs.size() == 0) begin
            $display("pulse_quantized_midi_looper_core verification clean");
        end else begin
            $display("pulse_quantized_midi_looper_core verification failed");
        end
        $finish;
    end

endmodule
